[rtl/spq_pkg.sv]
// Package for the sorted insert priority queue.
// Holds the operation and status codes, field widths and the entry and cell control types.
// Depends on nothing; every rtl file refers to it by scoped names.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int FUNC_W = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W = 5;
    localparam int BEAT_W = 56;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DROP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [DATA_W-1:0]        data;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t item;
    } cell_ctrl_t;

endpackage

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and moves it along with its neighbors.
// Uses spq_pkg for the entry and control types.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // An occupied slot whose priority is at least the new one stays ahead of it.
    assign keep = occupied && (entry_reg.prio >= ctrl.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push)
        begin
            if (keep)
            begin
                entry_next = entry_reg;
            end
            else if (left_keep)
            begin
                entry_next = ctrl.item;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/sorted_insert_priority_queue_unit.sv]
// Top level of the sorted insert priority queue: a chain of spq_cell slots and the count.
// Depends on spq_pkg and spq_cell.
//
// Usage:
// Commands arrive as beats on the s_ group; each carries func, item_data and item_priority.
// Func push inserts the entry behind all entries of equal or higher priority, take returns
// and removes the front entry, drop removes it without returning it.
// Every command yields exactly one result beat on the m_ group with status, top_data,
// top_priority and the fill count after the command.
// The result beat is registered and appears in the cycle after its command is accepted.
// The cell chain compares all slots against the new priority and shifts them together,
// so one command per cycle is sustained while results are taken.
// The result sits in an output register; s_tready is high while that register is empty or
// being taken in the same cycle, so a stalled receiver holds the result and back-pressures
// the command side after one beat.
// Reset empties the queue and drops any pending result; slot contents are not cleared.
// QUEUE_DEPTH sets the number of slots; fill_count reports the count in five bits.
module sorted_insert_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // func[1:0], item_data[33:2], item_priority[49:34], zero fill[55:50]
    input  logic [spq_pkg::BEAT_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], top_data[33:2], top_priority[49:34], fill_count[54:50], zero fill[55]
    output logic [spq_pkg::BEAT_W-1:0]   m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::FUNC_W-1:0] func;
    spq_pkg::entry_t            item;
    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       push_ok;
    logic                       pop_ok;
    spq_pkg::cell_ctrl_t        ctrl;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [31:0]                count_wide;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [spq_pkg::BEAT_W-1:0] out_data_reg;
    logic [spq_pkg::BEAT_W-1:0] out_data_next;

    logic [spq_pkg::STATUS_W-1:0] status;
    spq_pkg::entry_t              top;

    logic [QUEUE_DEPTH-1:0]     occ;
    logic [QUEUE_DEPTH-1:0]     keep;
    spq_pkg::entry_t            cell_entry [QUEUE_DEPTH];

    assign func = s_tdata[1:0];
    assign item.data = s_tdata[33:2];
    assign item.prio = s_tdata[49:34];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign push_ok = accept && (func == spq_pkg::FUNC_PUSH) && !full;
    assign pop_ok = accept && ((func == spq_pkg::FUNC_TAKE) || (func == spq_pkg::FUNC_DROP))
                    && !empty;

    assign ctrl.push = push_ok;
    assign ctrl.pop = pop_ok;
    assign ctrl.item = item;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_k;

            assign occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left_k = 1'b1;
                assign left_e = item;
            end
            else
            begin : g_mid
                assign left_k = keep[gi-1];
                assign left_e = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = item;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ[gi]),
                .left_keep   (left_k),
                .left_entry  (left_e),
                .right_entry (right_e),
                .keep        (keep[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = 32'(count_next);

    always_comb
    begin
        status = spq_pkg::STATUS_DONE;
        top = '0;
        unique case (func)
            spq_pkg::FUNC_PUSH:
            begin
                if (full)
                begin
                    status = spq_pkg::STATUS_FULL;
                end
            end
            spq_pkg::FUNC_TAKE:
            begin
                if (empty)
                begin
                    status = spq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    top = cell_entry[0];
                end
            end
            spq_pkg::FUNC_DROP:
            begin
                if (empty)
                begin
                    status = spq_pkg::STATUS_EMPTY;
                end
            end
            default:
            begin
                status = spq_pkg::STATUS_DONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next = {1'b0, count_wide[4:0], top.prio, top.data, status};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

[rtl/spq_checker.sv]
// Port-level checks for sorted_insert_priority_queue_unit, bound to the top level.
// Depends on spq_pkg for status codes and field widths.
module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [spq_pkg::BEAT_W-1:0] m_tdata
);

    localparam logic [4:0] FULL_FILL = 5'(QUEUE_DEPTH);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted command gave no result beat");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == spq_pkg::STATUS_EMPTY) |-> m_tdata[54:50] == 5'd0)
        else $error("empty status with entries held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == spq_pkg::STATUS_FULL)
        |-> (m_tdata[54:50] == FULL_FILL) && (m_tdata[49:2] == '0))
        else $error("full status with wrong count or data");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && !m_tdata[55])
        else $error("malformed result beat");

endmodule

bind sorted_insert_priority_queue_unit spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
